/* rtl/core/graph_dfs_bfs_traversal_unit_defines.svh */
// Assertion macros for the graph traversal unit.
// Needs clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef GRAPH_DFS_BFS_TRAVERSAL_UNIT_DEFINES_SVH
`define GRAPH_DFS_BFS_TRAVERSAL_UNIT_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define GDBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define GDBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/gdbt_pkg.sv */
// Shared types and constants of the graph traversal unit.
// No dependencies.
package gdbt_pkg;

  localparam int unsigned VertexW  = 7;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [VertexW-1:0] VertexCountRst = 7'd64;

  // register index = paddr >> 2
  typedef logic [ApbAddrW-3:0] reg_idx_t;
  localparam reg_idx_t RegVertexCount = '0;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_EDGE  = 2'd1,
    MODE_DFS   = 2'd2,
    MODE_BFS   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_RD_A,
    ST_EDGE_WR_A,
    ST_EDGE_RD_B,
    ST_EDGE_WR_B,
    ST_ROOT_SCAN,
    ST_ROOT_EMIT,
    ST_DFS_ADJ_RD,
    ST_DFS_EVAL,
    ST_DFS_POP,
    ST_BFS_Q_RD,
    ST_BFS_ADJ_RD,
    ST_BFS_CAND,
    ST_BFS_EMIT
  } state_e;

endpackage

/* rtl/core/graph_dfs_bfs_traversal_unit.sv */
// Graph traversal unit: undirected graph held as an adjacency bit matrix,
// walked depth-first or breadth-first on request.
// Input channel (valid/ready) takes one beat per command: clear graph, add
// edge, depth-first run or breadth-first run from start_vertex_i. A command
// with a vertex outside 1..min(vertex_count, MAX_VERTICES) is dropped silently.
// Output channel (valid/ready) gives one beat per visited vertex in visiting
// order; last_o marks the final vertex of a run. Clear and edge give none.
// Clear needs no RAM access; an edge is two read-modify-writes of the
// adjacency RAM. A run's first beat is its start vertex. Each vertex of a
// run costs an adjacency row read (registered RAM read) and a stack/queue
// read through the single read port of each RAM, plus root scanning when
// the graph is not connected. Commands are taken only between runs.
// A stalled output holds in the output register; the walk stops at the next
// vertex until that register frees up.
// Reset empties the graph at once (per-row valid flops), sets vertex_count
// to 64 and idles the engine; the work list RAM needs no init.
// Depends on gdbt_pkg, gdbt_ram and the assertion macro header.
`include "graph_dfs_bfs_traversal_unit_defines.svh"

module graph_dfs_bfs_traversal_unit import gdbt_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  // command channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [VertexW-1:0]  vertex_a_i,
  input  logic [VertexW-1:0]  vertex_b_i,
  input  logic [VertexW-1:0]  start_vertex_i,
  // visit channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [VertexW-1:0]  visited_vertex_o,
  output logic                last_o
);

  localparam int unsigned IDX_W = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);

  typedef logic [MAX_VERTICES-1:0] row_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // ---------------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------------
  logic [VertexW-1:0] vertex_count_q;
  reg_idx_t           reg_idx;

  assign reg_idx = paddr[ApbAddrW-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == RegVertexCount) ? ApbDataW'(vertex_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VertexCountRst;
    end else if (psel && penable && pwrite && pready && (reg_idx == RegVertexCount)) begin
      vertex_count_q <= pwdata[VertexW-1:0];
    end
  end

  // active vertex count, saturated to the matrix size
  cnt_t n_act;
  row_t valid_mask;

  always_comb begin
    if (vertex_count_q > VertexW'(MAX_VERTICES)) begin
      n_act = CNT_W'(MAX_VERTICES);
    end else begin
      n_act = vertex_count_q[CNT_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      valid_mask[i] = (CNT_W'(i) < n_act);
    end
  end

  logic a_ok, b_ok, s_ok;
  assign a_ok = (vertex_a_i != '0) && (vertex_a_i <= VertexW'(n_act));
  assign b_ok = (vertex_b_i != '0) && (vertex_b_i <= VertexW'(n_act));
  assign s_ok = (start_vertex_i != '0) && (start_vertex_i <= VertexW'(n_act));

  // ---------------------------------------------------------------------
  // Memories: adjacency rows and the stack/queue of vertex indexes
  // ---------------------------------------------------------------------
  logic adj_we, adj_re;
  idx_t adj_waddr, adj_raddr;
  row_t adj_wdata, adj_rdata;

  logic wl_we, wl_re;
  idx_t wl_waddr, wl_raddr, wl_wdata, wl_rdata;

  gdbt_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .re_i    (adj_re),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  gdbt_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_VERTICES)
  ) u_wl_ram (
    .clk_i   (clk_i),
    .we_i    (wl_we),
    .waddr_i (wl_waddr),
    .wdata_i (wl_wdata),
    .re_i    (wl_re),
    .raddr_i (wl_raddr),
    .rdata_o (wl_rdata)
  );

  // ---------------------------------------------------------------------
  // Engine state
  // ---------------------------------------------------------------------
  state_e state_q, state_d;
  row_t   row_valid_q, row_valid_d;   // row never written since clear reads as zero
  logic   row_ok_q;                   // valid bit of the row being read
  row_t   visited_q, visited_d;
  row_t   cand_q, cand_d;
  cnt_t   cnt_q, cnt_d;               // vertices emitted in this run
  cnt_t   head_q, head_d;
  cnt_t   tail_q, tail_d;
  idx_t   root_q, root_d;
  idx_t   cur_q, cur_d;
  idx_t   a_idx_q, a_idx_d;
  idx_t   b_idx_q, b_idx_d;
  logic   is_bfs_q, is_bfs_d;

  logic   out_valid_q;
  idx_t   out_vertex_q;
  logic   out_last_q;

  row_t   row_data, cand_now;
  row_t   low_src, low_onehot;
  idx_t   low_idx;
  logic   out_free;
  logic   emit, emit_last;
  idx_t   emit_idx;

  assign row_data  = row_ok_q ? adj_rdata : '0;
  assign cand_now  = row_data & valid_mask & ~visited_q;
  assign out_free  = !out_valid_q || out_ready_i;
  assign emit_last = ((cnt_q + CNT_W'(1)) == n_act);

  // lowest unvisited neighbor: isolate lowest set bit, then encode
  assign low_onehot = low_src & (~low_src + row_t'(1));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (low_onehot[i]) begin
        low_idx = low_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    row_valid_d = row_valid_q;
    visited_d   = visited_q;
    cand_d      = cand_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    tail_d      = tail_q;
    root_d      = root_q;
    cur_d       = cur_q;
    a_idx_d     = a_idx_q;
    b_idx_d     = b_idx_q;
    is_bfs_d    = is_bfs_q;

    in_ready_o  = 1'b0;
    adj_we      = 1'b0;
    adj_waddr   = a_idx_q;
    adj_wdata   = '0;
    adj_re      = 1'b0;
    adj_raddr   = cur_q;
    wl_we       = 1'b0;
    wl_waddr    = tail_q[IDX_W-1:0];
    wl_wdata    = '0;
    wl_re       = 1'b0;
    wl_raddr    = head_q[IDX_W-1:0];
    low_src     = '0;
    emit        = 1'b0;
    emit_idx    = root_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (mode_e'(mode_i))
            MODE_CLEAR: begin
              row_valid_d = '0;
            end
            MODE_EDGE: begin
              if (a_ok && b_ok) begin
                a_idx_d = IDX_W'(vertex_a_i - VertexW'(1));
                b_idx_d = IDX_W'(vertex_b_i - VertexW'(1));
                state_d = ST_EDGE_RD_A;
              end
            end
            MODE_DFS, MODE_BFS: begin
              if (s_ok) begin
                visited_d = '0;
                cnt_d     = '0;
                head_d    = '0;
                tail_d    = '0;
                root_d    = IDX_W'(start_vertex_i - VertexW'(1));
                is_bfs_d  = (mode_e'(mode_i) == MODE_BFS);
                state_d   = ST_ROOT_EMIT;
              end
            end
            default: ;
          endcase
        end
      end

      ST_EDGE_RD_A: begin
        adj_re    = 1'b1;
        adj_raddr = a_idx_q;
        state_d   = ST_EDGE_WR_A;
      end
      ST_EDGE_WR_A: begin
        adj_we               = 1'b1;
        adj_waddr            = a_idx_q;
        adj_wdata            = row_data | (row_t'(1) << b_idx_q);
        row_valid_d[a_idx_q] = 1'b1;
        state_d              = ST_EDGE_RD_B;
      end
      ST_EDGE_RD_B: begin
        adj_re    = 1'b1;
        adj_raddr = b_idx_q;
        state_d   = ST_EDGE_WR_B;
      end
      ST_EDGE_WR_B: begin
        adj_we               = 1'b1;
        adj_waddr            = b_idx_q;
        adj_wdata            = row_data | (row_t'(1) << a_idx_q);
        row_valid_d[b_idx_q] = 1'b1;
        state_d              = ST_IDLE;
      end

      // walk roots in rotated order until an unvisited one turns up
      ST_ROOT_SCAN: begin
        if (!visited_q[root_q]) begin
          state_d = ST_ROOT_EMIT;
        end else if (CNT_W'(root_q) == (n_act - CNT_W'(1))) begin
          root_d = '0;
        end else begin
          root_d = root_q + IDX_W'(1);
        end
      end

      ST_ROOT_EMIT: begin
        if (out_free) begin
          emit     = 1'b1;
          emit_idx = root_q;
          wl_we    = 1'b1;
          wl_wdata = root_q;
          cur_d    = root_q;
          if (is_bfs_q) begin
            wl_waddr = tail_q[IDX_W-1:0];
            tail_d   = tail_q + CNT_W'(1);
          end else begin
            // stack restarts at every root
            wl_waddr = '0;
            tail_d   = CNT_W'(1);
          end
          if (emit_last) begin
            state_d = ST_IDLE;
          end else if (is_bfs_q) begin
            state_d = ST_BFS_Q_RD;
          end else begin
            state_d = ST_DFS_ADJ_RD;
          end
        end
      end

      ST_DFS_ADJ_RD: begin
        adj_re    = 1'b1;
        adj_raddr = cur_q;
        state_d   = ST_DFS_EVAL;
      end
      ST_DFS_EVAL: begin
        low_src = cand_now;
        if (cand_now != '0) begin
          if (out_free) begin
            emit     = 1'b1;
            emit_idx = low_idx;
            wl_we    = 1'b1;
            wl_waddr = tail_q[IDX_W-1:0];
            wl_wdata = low_idx;
            tail_d   = tail_q + CNT_W'(1);
            cur_d    = low_idx;
            state_d  = emit_last ? ST_IDLE : ST_DFS_ADJ_RD;
          end
        end else begin
          // dead end: pop, fetch new top of stack
          tail_d = tail_q - CNT_W'(1);
          if (tail_q == CNT_W'(1)) begin
            state_d = ST_ROOT_SCAN;
          end else begin
            wl_re    = 1'b1;
            wl_raddr = IDX_W'(tail_q - CNT_W'(2));
            state_d  = ST_DFS_POP;
          end
        end
      end
      ST_DFS_POP: begin
        adj_re    = 1'b1;
        adj_raddr = wl_rdata;
        cur_d     = wl_rdata;
        state_d   = ST_DFS_EVAL;
      end

      ST_BFS_Q_RD: begin
        if (head_q < tail_q) begin
          wl_re    = 1'b1;
          wl_raddr = head_q[IDX_W-1:0];
          head_d   = head_q + CNT_W'(1);
          state_d  = ST_BFS_ADJ_RD;
        end else begin
          state_d = ST_ROOT_SCAN;
        end
      end
      ST_BFS_ADJ_RD: begin
        adj_re    = 1'b1;
        adj_raddr = wl_rdata;
        state_d   = ST_BFS_CAND;
      end
      ST_BFS_CAND: begin
        // snapshot of the neighbors to enqueue from this vertex
        cand_d  = cand_now;
        state_d = ST_BFS_EMIT;
      end
      ST_BFS_EMIT: begin
        low_src = cand_q;
        if (cand_q != '0) begin
          if (out_free) begin
            emit     = 1'b1;
            emit_idx = low_idx;
            wl_we    = 1'b1;
            wl_waddr = tail_q[IDX_W-1:0];
            wl_wdata = low_idx;
            tail_d   = tail_q + CNT_W'(1);
            cand_d   = cand_q & ~low_onehot;
            state_d  = emit_last ? ST_IDLE : ST_BFS_EMIT;
          end
        end else begin
          state_d = ST_BFS_Q_RD;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      visited_d[emit_idx] = 1'b1;
      cnt_d               = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_valid_q <= '0;
      row_ok_q    <= 1'b0;
      visited_q   <= '0;
      cnt_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      root_q      <= '0;
      cur_q       <= '0;
      is_bfs_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_valid_q <= row_valid_d;
      visited_q   <= visited_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      root_q      <= root_d;
      cur_q       <= cur_d;
      is_bfs_q    <= is_bfs_d;
      if (adj_re) begin
        row_ok_q <= row_valid_q[adj_raddr];
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    a_idx_q <= a_idx_d;
    b_idx_q <= b_idx_d;
    if (emit) begin
      out_vertex_q <= emit_idx;
      out_last_q   <= emit_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign visited_vertex_o = VertexW'(out_vertex_q) + VertexW'(1);
  assign last_o           = out_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `GDBT_ASSERT(a_emit_unvisited, emit |-> !visited_q[emit_idx], "vertex emitted twice")
  `GDBT_ASSERT(a_emit_no_overwrite, emit |-> out_free, "output beat overwritten")
  `GDBT_ASSERT_NEXT(a_last_ends_run, emit && emit_last, state_q == ST_IDLE,
                    "run continued after last vertex")
  `GDBT_ASSERT_NEXT(a_clear_rows, in_valid_i && in_ready_o && (mode_i == MODE_CLEAR),
                    row_valid_q == '0, "clear left rows valid")

endmodule

/* rtl/core/gdbt_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module gdbt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/sv/tb_graph_dfs_bfs_traversal_unit.sv */
// Self-checking testbench for graph_dfs_bfs_traversal_unit.
// Holds its own graph model and a scoreboard of expected visit beats.
// Depends on gdbt_pkg and the RTL of the traversal unit only.
`timescale 1ns / 100ps

module tb_graph_dfs_bfs_traversal_unit;
  import gdbt_pkg::*;

  localparam int unsigned MaxVerts    = 64;
  localparam int unsigned DrainCycles = 500;     // quiet time; covers an edge update in flight
  localparam int unsigned HoldCycles  = 400;     // long receiver hold-off
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned NumPhases   = 10;
  localparam int unsigned PhaseItems  = 11;

  // one expected beat on the visit channel
  typedef struct packed {
    logic [VertexW-1:0] vertex;
    logic               last;
  } visit_t;

  // Graph model plus queue of visit beats still owed by the block.
  class visit_scoreboard;
    logic [63:0]        adj_rows [MaxVerts];
    logic [VertexW-1:0] count_reg;
    visit_t             pending [$];
    int unsigned        errors;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      count_reg = VertexCountRst;
      errors    = 0;
    endfunction

    function void set_count(logic [VertexW-1:0] v);
      count_reg = v;
    endfunction

    // count register saturates at the graph size
    function int unsigned active_n();
      return (count_reg > MaxVerts) ? MaxVerts : int'(count_reg);
    endfunction

    // Walk every vertex in use, roots tried in rotated order from s.
    function void walk(bit depth_first, int unsigned s, int unsigned n);
      logic [63:0] in_use;
      logic [63:0] seen;
      logic [63:0] cand;
      int unsigned order [$];
      int unsigned work [$];
      int unsigned r;
      int unsigned u;
      int unsigned w;
      visit_t      beat;
      in_use = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      seen   = '0;
      for (int k = 0; k < n; k++) begin
        r = (s - 1 + k) % n + 1;
        if (seen[r-1]) continue;
        seen[r-1] = 1'b1;
        order.push_back(r);
        work.push_back(r);
        while (work.size() > 0) begin
          if (depth_first) begin
            // stack: descend into lowest unvisited neighbor, else pop
            u    = work[$];
            cand = adj_rows[u-1] & in_use & ~seen;
            if (cand == '0) begin
              void'(work.pop_back());
            end else begin
              w = 0;
              while (!cand[w]) w++;
              seen[w] = 1'b1;
              order.push_back(w + 1);
              work.push_back(w + 1);
            end
          end else begin
            // queue: all unvisited neighbors, ascending
            u    = work.pop_front();
            cand = adj_rows[u-1] & in_use & ~seen;
            for (int i = 0; i < 64; i++) begin
              if (cand[i]) begin
                seen[i] = 1'b1;
                order.push_back(i + 1);
                work.push_back(i + 1);
              end
            end
          end
        end
      end
      foreach (order[i]) begin
        beat.vertex = VertexW'(order[i]);
        beat.last   = (i == order.size() - 1);
        pending.push_back(beat);
      end
    endfunction

    // Accepted command beat; returns 0 when the block drops it.
    function bit note_command(mode_e m, logic [VertexW-1:0] a, logic [VertexW-1:0] b,
                              logic [VertexW-1:0] s);
      int unsigned n;
      n = active_n();
      case (m)
        MODE_CLEAR: begin
          foreach (adj_rows[i]) adj_rows[i] = '0;
          return 1'b1;
        end
        MODE_EDGE: begin
          if (a < 1 || a > n || b < 1 || b > n) return 1'b0;
          adj_rows[a-1][b-1] = 1'b1;
          adj_rows[b-1][a-1] = 1'b1;
          return 1'b1;
        end
        default: begin
          if (s < 1 || s > n) return 1'b0;
          walk(m == MODE_DFS, s, n);
          return 1'b1;
        end
      endcase
    endfunction

    function void check_visit(logic [VertexW-1:0] v, logic l);
      visit_t exp_beat;
      if (pending.size() == 0) begin
        $error("visited_vertex: expected no beat, actual %0d", v);
        errors++;
        return;
      end
      exp_beat = pending.pop_front();
      if (v !== exp_beat.vertex) begin
        $error("visited_vertex: expected %0d, actual %0d", exp_beat.vertex, v);
        errors++;
      end
      if (l !== exp_beat.last) begin
        $error("last: expected %0b, actual %0b", exp_beat.last, l);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                cmd_valid = 1'b0;
  logic                in_ready_o;
  logic [1:0]          cmd_mode = MODE_CLEAR;
  logic [VertexW-1:0]  cmd_a = '0;
  logic [VertexW-1:0]  cmd_b = '0;
  logic [VertexW-1:0]  cmd_start = '0;
  logic                out_valid_o;
  logic                visit_ready = 1'b0;
  logic [VertexW-1:0]  visited_vertex_o;
  logic                last_o;

  visit_scoreboard sb = new();

  // idle percentages of each side, changed per phase
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 80;
  bit          hold_req = 1'b0;    // asks the receiver for a long hold-off
  int unsigned cycle_cnt = 0;

  graph_dfs_bfs_traversal_unit #(.MAX_VERTICES(MaxVerts)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (cmd_valid),
    .in_ready_o      (in_ready_o),
    .mode_i          (cmd_mode),
    .vertex_a_i      (cmd_a),
    .vertex_b_i      (cmd_b),
    .start_vertex_i  (cmd_start),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (visit_ready),
    .visited_vertex_o(visited_vertex_o),
    .last_o          (last_o)
  );

  always #1 clk_i = ~clk_i;

  // Drive one command beat. Random gap first (valid drops only when a gap
  // is taken, so valid never toggles twice in one step), then hold until
  // the handshake completes and hand the beat to the scoreboard.
  task automatic send_cmd(input mode_e m, input logic [VertexW-1:0] a,
                          input logic [VertexW-1:0] b, input logic [VertexW-1:0] s,
                          output bit acted);
    int unsigned gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_valid <= 1'b1;
    cmd_mode  <= m;
    cmd_a     <= a;
    cmd_b     <= b;
    cmd_start <= s;
    do @(posedge clk_i); while (!in_ready_o);
    acted = sb.note_command(m, a, b, s);
  endtask

  // Drop valid, wait out every owed beat, then idle a while so an edge
  // update still going through the adjacency RAM completes.
  task automatic settle();
    cmd_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // setup cycle, then access cycle; pready is tied high
  task automatic write_count(input logic [VertexW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegVertexCount, 2'b00};
    pwdata  <= ApbDataW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_count(v);
  endtask

  // mostly vertices in use, some anywhere in the 7-bit field
  function automatic logic [VertexW-1:0] pick_vertex(int unsigned n);
    if (n > 0 && $urandom_range(99) < 88) return VertexW'($urandom_range(n, 1));
    return VertexW'($urandom_range(127, 0));
  endfunction

  // Visit channel: check every accepted beat, then pick next ready.
  // A hold request parks ready low for HoldCycles so the output register
  // and then the command channel back up.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && visit_ready) sb.check_visit(visited_vertex_o, last_o);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        visit_ready <= 1'b0;
      end else begin
        visit_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    bit                 acted;
    int unsigned        n;
    int unsigned        done;
    int unsigned        tries;
    int unsigned        pick;
    mode_e              m;
    logic [VertexW-1:0] cnt_val;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: count at reset value (64). Edges at the extremes, a self loop,
    // endpoints and starts out of range, DFS from 1 and 64, BFS from 1 and 63.
    send_cmd(MODE_EDGE, 7'd1, 7'd64, 7'd0, acted);
    send_cmd(MODE_EDGE, 7'd1, 7'd2, 7'd0, acted);
    send_cmd(MODE_EDGE, 7'd64, 7'd63, 7'd0, acted);
    send_cmd(MODE_EDGE, 7'd5, 7'd5, 7'd0, acted);
    send_cmd(MODE_EDGE, 7'd0, 7'd3, 7'd0, acted);
    send_cmd(MODE_EDGE, 7'd3, 7'd65, 7'd0, acted);
    send_cmd(MODE_EDGE, 7'd127, 7'd127, 7'd127, acted);
    send_cmd(MODE_EDGE, 7'd2, 7'd40, 7'd0, acted);
    send_cmd(MODE_DFS, 7'd0, 7'd0, 7'd1, acted);
    send_cmd(MODE_BFS, 7'd0, 7'd0, 7'd1, acted);
    send_cmd(MODE_DFS, 7'd0, 7'd0, 7'd64, acted);
    send_cmd(MODE_BFS, 7'd0, 7'd0, 7'd63, acted);
    send_cmd(MODE_DFS, 7'd0, 7'd0, 7'd0, acted);
    send_cmd(MODE_BFS, 7'd0, 7'd0, 7'd127, acted);
    send_cmd(MODE_DFS, 7'd0, 7'd0, 7'd2, acted);
    send_cmd(MODE_CLEAR, 7'd0, 7'd0, 7'd0, acted);
    send_cmd(MODE_BFS, 7'd0, 7'd0, 7'd10, acted);
    send_cmd(MODE_EDGE, 7'd1, 7'd2, 7'd0, acted);
    settle();

    // shrink the count to 3: edge 3-4 is then out of range and dropped
    write_count(7'd3);
    send_cmd(MODE_DFS, 7'd0, 7'd0, 7'd2, acted);
    send_cmd(MODE_EDGE, 7'd3, 7'd4, 7'd0, acted);
    send_cmd(MODE_EDGE, 7'd1, 7'd3, 7'd0, acted);
    send_cmd(MODE_BFS, 7'd0, 7'd0, 7'd3, acted);
    send_cmd(MODE_DFS, 7'd0, 7'd0, 7'd3, acted);

    // Random phases, each at its own count. Counts 0, 1, 64 and values
    // past 64 (saturating) are among them.
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      send_idle_pct = (p < 4) ? 30 : ((p < 7) ? 80 : 0);
      recv_idle_pct = (p < 4) ? 80 : ((p < 7) ? 30 : 0);
      case (p)
        0:       cnt_val = 7'd64;
        1:       cnt_val = 7'd1;
        2:       cnt_val = 7'd127;
        4:       cnt_val = 7'd2;
        5:       cnt_val = 7'd0;
        6:       cnt_val = VertexW'($urandom_range(64, 3));
        8:       cnt_val = 7'd100;
        default: cnt_val = VertexW'($urandom_range(16, 3));
      endcase
      write_count(cnt_val);
      n = sb.active_n();

      // back-pressure: receiver parks while full-size walks keep coming
      if (p == 0) begin
        hold_req = 1'b1;
        send_cmd(MODE_DFS, 7'd0, 7'd0, 7'd1, acted);
        send_cmd(MODE_BFS, 7'd0, 7'd0, 7'd64, acted);
        send_cmd(MODE_DFS, 7'd0, 7'd0, 7'd32, acted);
      end

      if ($urandom_range(2) == 0) send_cmd(MODE_CLEAR, pick_vertex(n), pick_vertex(n),
                                           pick_vertex(n), acted);
      done  = 0;
      tries = 0;
      // mostly edge building with walks in between; dropped beats don't count
      while (done < PhaseItems && tries < 3 * PhaseItems) begin
        pick = $urandom_range(99);
        if (pick < 4)       m = MODE_CLEAR;
        else if (pick < 55) m = MODE_EDGE;
        else if (pick < 77) m = MODE_DFS;
        else                m = MODE_BFS;
        send_cmd(m, pick_vertex(n), pick_vertex(n), pick_vertex(n), acted);
        done += acted;
        tries++;
      end
    end
    settle();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/gdbt_pkg.sv
rtl/core/gdbt_ram.sv
rtl/core/graph_dfs_bfs_traversal_unit.sv
tb/sv/tb_graph_dfs_bfs_traversal_unit.sv
